FILE: src/assert_macros.svh
// Assertion helper macros shared by the typematic controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define KAR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kar assertion failed");
// Next-cycle implication, checked out of reset.
`define KAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kar assertion failed");
`else
`define KAR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define KAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/kar_pkg.sv
// Types, codes and defaults for the key auto-repeat controller.
package kar_pkg;

  // Parameter defaults
  localparam int NumButtonsDef = 5;
  localparam int CountWidthDef = 16;

  // Buttons that map to an event code
  localparam int NumEvButtons = 5;

  localparam logic [15:0] RepeatDelayRst = 16'd50;

  // Request kinds
  localparam logic [1:0] REQ_KEY_DOWN = 2'd0;
  localparam logic [1:0] REQ_KEY_UP   = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;
  localparam logic [1:0] REQ_QUIT     = 2'd3;

  // Key codes
  localparam logic [2:0] KEY_OTHER  = 3'd0;
  localparam logic [2:0] KEY_ESCAPE = 3'd1;
  localparam logic [2:0] KEY_LEFT   = 3'd2;
  localparam logic [2:0] KEY_RIGHT  = 3'd3;
  localparam logic [2:0] KEY_UP     = 3'd4;
  localparam logic [2:0] KEY_DOWN   = 3'd5;
  localparam logic [2:0] KEY_RETURN = 3'd6;

  // Event codes
  localparam logic [2:0] EV_LEFT       = 3'd0;
  localparam logic [2:0] EV_RIGHT      = 3'd1;
  localparam logic [2:0] EV_UP         = 3'd2;
  localparam logic [2:0] EV_DOWN       = 3'd3;
  localparam logic [2:0] EV_CLICK      = 3'd4;
  localparam logic [2:0] EV_QUIT       = 3'd5;
  localparam logic [2:0] EV_CLICK_DOWN = 3'd6;
  localparam logic [2:0] EV_CLICK_UP   = 3'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] key_code;
    logic       flipped;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_of_run;
  } out_item_t;

  // Commands handed from the front to the back
  typedef enum logic [2:0] {
    CMD_QUIT          = 3'd0,
    CMD_PRESS_DIR     = 3'd1,
    CMD_PRESS_CLICK   = 3'd2,
    CMD_RELEASE_DIR   = 3'd3,
    CMD_RELEASE_CLICK = 3'd4,
    CMD_TICK          = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] btn;
  } cmd_t;

endpackage

FILE: src/kar_front.sv
// Input side: accept items and classify them into button commands.
module kar_front (
  input  logic             push,
  output logic             full,
  input  kar_pkg::in_item_t in_item_i,
  input  logic             cmd_full_i,
  output logic             cmd_wr_o,
  output kar_pkg::cmd_t    cmd_o
);

  logic       accept;
  logic       has_cmd;
  logic       is_dir;
  logic [2:0] dir_btn;

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  // Map a direction key to its button, swapped when flipped
  assign is_dir  = in_item_i.key_code inside {[kar_pkg::KEY_LEFT:kar_pkg::KEY_DOWN]};
  assign dir_btn = (in_item_i.key_code - kar_pkg::KEY_LEFT) ^ {2'b00, in_item_i.flipped};

  // Classify; items that cause nothing are dropped here
  always_comb begin
    has_cmd    = 1'b0;
    cmd_o.kind = kar_pkg::CMD_QUIT;
    cmd_o.btn  = dir_btn;
    case (in_item_i.req_type)
      kar_pkg::REQ_KEY_DOWN: begin
        if (in_item_i.key_code == kar_pkg::KEY_ESCAPE) begin
          has_cmd    = 1'b1;
          cmd_o.kind = kar_pkg::CMD_QUIT;
        end else if (is_dir) begin
          has_cmd    = 1'b1;
          cmd_o.kind = kar_pkg::CMD_PRESS_DIR;
        end else if (in_item_i.key_code == kar_pkg::KEY_RETURN) begin
          has_cmd    = 1'b1;
          cmd_o.kind = kar_pkg::CMD_PRESS_CLICK;
          cmd_o.btn  = kar_pkg::EV_CLICK;
        end
      end
      kar_pkg::REQ_KEY_UP: begin
        if (is_dir) begin
          has_cmd    = 1'b1;
          cmd_o.kind = kar_pkg::CMD_RELEASE_DIR;
        end else if (in_item_i.key_code == kar_pkg::KEY_RETURN) begin
          has_cmd    = 1'b1;
          cmd_o.kind = kar_pkg::CMD_RELEASE_CLICK;
          cmd_o.btn  = kar_pkg::EV_CLICK;
        end
      end
      kar_pkg::REQ_TICK: begin
        has_cmd    = 1'b1;
        cmd_o.kind = kar_pkg::CMD_TICK;
      end
      default: begin
        has_cmd    = 1'b1;
        cmd_o.kind = kar_pkg::CMD_QUIT;
      end
    endcase
  end

  assign cmd_wr_o = accept && has_cmd;

endmodule

FILE: src/kar_cmd_fifo.sv
// Two-entry command queue between the front and the back.
`include "assert_macros.svh"
module kar_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  kar_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output kar_pkg::cmd_t rd_data_o
);

  kar_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the written command
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `KAR_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, wr_i, !full_o)
  `KAR_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, rd_i, valid_o)
  `KAR_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, count_q != 2'd3)

endmodule

FILE: src/kar_back.sv
// Back end: button state, repeat countdowns, tick scan and result register.
`include "assert_macros.svh"
module kar_back #(
  parameter int NUM_BUTTONS = kar_pkg::NumButtonsDef,
  parameter int COUNT_WIDTH = kar_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               cmd_valid_i,
  input  kar_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output kar_pkg::out_item_t out_item_o
);

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [31:0] CntMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EMIT2 = 3'b010,
    S_SCAN  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [15:0]             delay_q;
  logic [NUM_BUTTONS-1:0]  held_q, held_d;
  logic [COUNT_WIDTH-1:0]  cnt_q [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0]  cnt_d [NUM_BUTTONS];
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    out_valid_q, out_valid_d;
  kar_pkg::out_item_t      out_q, out_d;
  logic                    out_load;
  logic                    out_free;
  logic [31:0]             delay32;
  logic [COUNT_WIDTH-1:0]  load_val;
  logic [NUM_BUTTONS-1:0]  fire;
  logic                    later_fire;
  logic [7:0]              idx8;
  logic [COUNT_WIDTH-1:0]  cur_cnt;

  assign cfg_ready_o = 1'b1;
  assign empty       = !out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || pop;

  // Reload value, saturated to the counter width
  assign delay32  = 32'(delay_q);
  assign load_val = COUNT_WIDTH'((delay32 > CntMax) ? CntMax : delay32);

  assign idx8    = 8'(idx_q);
  assign cur_cnt = cnt_q[idx_q];

  // Buttons that will emit on this tick, and whether one follows the current index
  always_comb begin
    later_fire = 1'b0;
    for (int j = 0; j < NUM_BUTTONS; j++) begin
      fire[j] = held_q[j] && (cnt_q[j] == COUNT_WIDTH'(1)) && (j < kar_pkg::NumEvButtons);
      if (j > int'(idx_q)) begin
        later_fire = later_fire | fire[j];
      end
    end
  end

  // Command sequencer
  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    out_load  = 1'b0;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            kar_pkg::CMD_QUIT: begin
              out_load = 1'b1;
              out_d    = '{event_code: kar_pkg::EV_QUIT, last_of_run: 1'b1};
            end
            kar_pkg::CMD_PRESS_DIR: begin
              for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (8'(b) == 8'(cmd_i.btn)) begin
                  held_d[b] = 1'b1;
                  cnt_d[b]  = load_val;
                end
              end
              out_load = 1'b1;
              out_d    = '{event_code: cmd_i.btn, last_of_run: 1'b1};
            end
            kar_pkg::CMD_PRESS_CLICK: begin
              for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (8'(b) == 8'(cmd_i.btn)) begin
                  held_d[b] = 1'b1;
                  cnt_d[b]  = '0;
                end
              end
              out_load = 1'b1;
              out_d    = '{event_code: kar_pkg::EV_CLICK, last_of_run: 1'b0};
              state_d  = S_EMIT2;
            end
            kar_pkg::CMD_RELEASE_DIR: begin
              for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (8'(b) == 8'(cmd_i.btn)) begin
                  held_d[b] = 1'b0;
                end
              end
            end
            kar_pkg::CMD_RELEASE_CLICK: begin
              for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (8'(b) == 8'(cmd_i.btn)) begin
                  held_d[b] = 1'b0;
                end
              end
              out_load = 1'b1;
              out_d    = '{event_code: kar_pkg::EV_CLICK_UP, last_of_run: 1'b1};
            end
            kar_pkg::CMD_TICK: begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{event_code: kar_pkg::EV_CLICK_DOWN, last_of_run: 1'b1};
          state_d  = S_IDLE;
        end
      end
      S_SCAN: begin
        // Count down one button a cycle while the result register is free, reloading and emitting on expiry
        if (out_free) begin
          if (held_q[idx_q] && (cur_cnt != '0)) begin
            if (cur_cnt == COUNT_WIDTH'(1)) begin
              cnt_d[idx_q] = load_val;
              if (idx8 < 8'(kar_pkg::NumEvButtons)) begin
                out_load = 1'b1;
                out_d    = '{event_code: idx8[2:0], last_of_run: !later_fire};
              end
            end else begin
              cnt_d[idx_q] = cur_cnt - COUNT_WIDTH'(1);
            end
          end
          if (idx_q == IdxW'(NUM_BUTTONS - 1)) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !pop) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      delay_q     <= kar_pkg::RepeatDelayRst;
      held_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i) begin
        delay_q <= cfg_data_i;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  `KAR_ASSERT_IMPL(a_pop_in_idle, clk_i, rst_ni, cmd_pop_o, state_q == S_IDLE)
  `KAR_ASSERT_IMPL(a_scan_range, clk_i, rst_ni, state_q == S_SCAN, idx_q <= IdxW'(NUM_BUTTONS - 1))
  `KAR_ASSERT_IMPL(a_click_pending, clk_i, rst_ni, state_q == S_EMIT2, out_valid_q && (out_q.event_code == kar_pkg::EV_CLICK) && !out_q.last_of_run)
  `KAR_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_q && !pop, out_valid_q && $stable(out_q))

endmodule

FILE: src/key_auto_repeat_controller.sv
// Top level of the typematic auto-repeat controller for five logical buttons.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | push / full          | in_item_i  (req_type, key_code, flipped)
//  result   | empty / pop          | out_item_o (event_code, last_of_run)
//  config   | cfg_valid_i / _ready | cfg_data_i (repeat_delay)
//
// Key and quit commands are executed by the back end from S_IDLE (click press: via S_EMIT2).
// A tick is taken as a command, then each button counter is visited in turn while the
// result register is free, through the single countdown update path in the back end.
// A two-entry command queue decouples classification from execution, and the
// result register takes a new item in the cycle the old one is popped.
// Reset clears held flags, countdowns and both queues; repeat_delay returns to 50.
module key_auto_repeat_controller #(
  parameter int NUM_BUTTONS = kar_pkg::NumButtonsDef,
  parameter int COUNT_WIDTH = kar_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  kar_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output kar_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  logic          cmd_wr;
  kar_pkg::cmd_t cmd_in;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_valid;
  kar_pkg::cmd_t cmd_out;

  // Classify incoming items
  kar_front u_front (
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .cmd_full_i (cmd_full),
    .cmd_wr_o   (cmd_wr),
    .cmd_o      (cmd_in)
  );

  // Queue commands between the two halves
  kar_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_wr),
    .wr_data_i (cmd_in),
    .full_o    (cmd_full),
    .rd_i      (cmd_pop),
    .valid_o   (cmd_valid),
    .rd_data_o (cmd_out)
  );

  // Execute commands and produce results
  kar_back #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule
